// ----- sv/lsg_pkg.sv -----
// Shared types and constants for the LFSR star generator.
package lsg_pkg;

    localparam int LFSR_W   = 17;
    localparam int POS_W    = 16;
    localparam int COORD_W  = 8;
    localparam int SPEED_W  = 3;
    localparam int COLOR_W  = 5;

    localparam logic [LFSR_W-1:0]  LFSR_EVEN_START = 17'h00000;
    localparam logic [LFSR_W-1:0]  LFSR_ODD_START  = 17'h1fc71;
    localparam logic [COORD_W-1:0] LFSR_LOW_ONES   = 8'hff;
    localparam logic [POS_W-1:0]   SCROLL_BIAS     = 16'd9;
    localparam logic [COORD_W-1:0] HCOND_SKEW      = 8'd8;

    localparam logic [COORD_W-1:0] PALETTE_BASE_RST = 8'd96;
    localparam logic [COORD_W-1:0] WINDOW_FIRST_RST = 8'd0;
    localparam logic [COORD_W-1:0] WINDOW_LAST_RST  = 8'd255;

    typedef enum logic [1:0] {
        OP_PIXEL       = 2'd0,
        OP_FRAME_END   = 2'd1,
        OP_SET_SPEED   = 2'd2,
        OP_STAR_ENABLE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_PALETTE_BASE   = 2'd0,
        CFG_SKIP_VERTICAL  = 2'd1,
        CFG_WINDOW_FIRST_X = 2'd2,
        CFG_WINDOW_LAST_X  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0] palette_base;
        logic               skip_vertical_bit;
        logic [COORD_W-1:0] window_first_x;
        logic [COORD_W-1:0] window_last_x;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] star_pen;
        logic [COORD_W-1:0] pixel_y;
        logic [COORD_W-1:0] pixel_x;
        logic               star_write;
    } t_pix;

endpackage

// ----- sv/lfsr_starfield_generator_unit.sv -----
// Top level of the LFSR star generator with stream ports and config port.
// One item is accepted per clock and yields exactly one result transfer, registered and
// offered in the following cycle; the LFSR and position update is registered with each
// item, so the sustained throughput is one item per cycle whenever the output side takes
// results. The result register lets a new item enter in the same cycle that the waiting result is taken.
// Operation 0 tests a pixel for a star, 1 ends a frame, 2 loads the scroll speed and
// 3 enables the generator; configuration writes take effect on the following item.
module lfsr_starfield_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [1:0] operation, [4:2] speed_value, [7:5] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] star_write, [8:1] pixel_x, [16:9] pixel_y,
                                        // [24:17] star_pen, [31:25] zero
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    lsg_pkg::t_cfg                      r_cfg;
    logic                               r_enable;
    logic                               r_phase;
    logic [lsg_pkg::POS_W-1:0]          r_offset;
    logic [lsg_pkg::LFSR_W-1:0]         r_start;
    logic [lsg_pkg::SPEED_W-1:0]        r_speed;
    logic [lsg_pkg::LFSR_W-1:0]         r_lfsr;
    logic [lsg_pkg::POS_W-1:0]          r_index;
    logic                               r_out_valid;
    lsg_pkg::t_pix                      r_out;

    logic                               n_enable;
    logic                               n_phase;
    logic [lsg_pkg::POS_W-1:0]          n_offset;
    logic [lsg_pkg::LFSR_W-1:0]         n_start;
    logic [lsg_pkg::SPEED_W-1:0]        n_speed;
    logic [lsg_pkg::LFSR_W-1:0]         n_lfsr;
    logic [lsg_pkg::POS_W-1:0]          n_index;
    lsg_pkg::t_pix                      n_out;

    lsg_pkg::t_pix                      pix;
    logic [lsg_pkg::LFSR_W-1:0]         pix_next_lfsr;
    lsg_pkg::t_op                       op;
    logic                               in_xfer;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign op            = lsg_pkg::t_op'(s_axis_tdata[1:0]);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    lsg_star_test u_star_test (
        .i_cfg       (r_cfg),
        .i_enable    (r_enable),
        .i_offset    (r_offset),
        .i_index     (r_index),
        .i_lfsr      (r_lfsr),
        .o_pix       (pix),
        .o_next_lfsr (pix_next_lfsr)
    );

    always_comb begin
        n_enable = r_enable;
        n_phase  = r_phase;
        n_offset = r_offset;
        n_start  = r_start;
        n_speed  = r_speed;
        n_lfsr   = r_lfsr;
        n_index  = r_index;
        n_out    = '0;
        unique case (op)
            lsg_pkg::OP_PIXEL: begin
                n_out = pix;
                if (r_enable) begin
                    n_lfsr  = pix_next_lfsr;
                    n_index = r_index + 1'b1;
                end
            end
            lsg_pkg::OP_FRAME_END: begin
                if (r_enable) begin
                    n_phase = ~r_phase;
                    // The scroll only moves when the phase returns to even.
                    if (r_phase) begin
                        n_offset = r_offset + {12'd0, r_speed, 1'b0} - lsg_pkg::SCROLL_BIAS;
                        n_start  = lsg_pkg::LFSR_EVEN_START;
                    end else begin
                        n_start  = lsg_pkg::LFSR_ODD_START;
                    end
                end
                n_lfsr  = n_start;
                n_index = '0;
            end
            lsg_pkg::OP_SET_SPEED: begin
                n_speed = s_axis_tdata[4:2];
            end
            lsg_pkg::OP_STAR_ENABLE: begin
                if (!r_enable) begin
                    n_offset = '0;
                end
                n_enable = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.palette_base      <= lsg_pkg::PALETTE_BASE_RST;
            r_cfg.skip_vertical_bit <= 1'b0;
            r_cfg.window_first_x    <= lsg_pkg::WINDOW_FIRST_RST;
            r_cfg.window_last_x     <= lsg_pkg::WINDOW_LAST_RST;
        end else if (i_cfg_we) begin
            unique case (lsg_pkg::t_cfg_reg'(i_cfg_index))
                lsg_pkg::CFG_PALETTE_BASE:   r_cfg.palette_base      <= i_cfg_data;
                lsg_pkg::CFG_SKIP_VERTICAL:  r_cfg.skip_vertical_bit <= i_cfg_data[0];
                lsg_pkg::CFG_WINDOW_FIRST_X: r_cfg.window_first_x    <= i_cfg_data;
                lsg_pkg::CFG_WINDOW_LAST_X:  r_cfg.window_last_x     <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_phase     <= 1'b0;
            r_offset    <= '0;
            r_start     <= '0;
            r_speed     <= '0;
            r_lfsr      <= '0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_enable <= n_enable;
                r_phase  <= n_phase;
                r_offset <= n_offset;
                r_start  <= n_start;
                r_speed  <= n_speed;
                r_lfsr   <= n_lfsr;
                r_index  <= n_index;
            end
            if (s_axis_tready) begin
                r_out_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- sv/lsg_star_test.sv -----
// Per-pixel star test: position, LFSR feedback, window check and pen.
module lsg_star_test (
    input  lsg_pkg::t_cfg                   i_cfg,
    input  logic                            i_enable,
    input  logic [lsg_pkg::POS_W-1:0]       i_offset,
    input  logic [lsg_pkg::POS_W-1:0]       i_index,
    input  logic [lsg_pkg::LFSR_W-1:0]      i_lfsr,
    output lsg_pkg::t_pix                   o_pix,
    output logic [lsg_pkg::LFSR_W-1:0]      o_next_lfsr
);

    logic [lsg_pkg::POS_W-1:0]   pos;
    logic [lsg_pkg::COORD_W-1:0] x;
    logic [lsg_pkg::COORD_W-1:0] y;
    logic [lsg_pkg::COORD_W-1:0] x_skew;
    logic                        fb;
    logic                        hcond;
    logic                        vcond;
    logic                        star;

    always_comb begin
        pos    = i_offset + i_index;
        x      = pos[lsg_pkg::COORD_W-1:0];
        y      = pos[lsg_pkg::POS_W-1:lsg_pkg::COORD_W];
        fb     = ~i_lfsr[16] ^ i_lfsr[5];
        // Only bit 4 of x + 8 matters, so the carry out of the byte is irrelevant.
        x_skew = x + lsg_pkg::HCOND_SKEW;
        hcond  = x_skew[4];
        vcond  = i_cfg.skip_vertical_bit | y[0];
        star   = i_enable && (hcond == vcond)
                 && (i_lfsr[lsg_pkg::COORD_W-1:0] == lsg_pkg::LFSR_LOW_ONES)
                 && !fb
                 && (x >= i_cfg.window_first_x) && (x <= i_cfg.window_last_x);

        o_pix.star_write = star;
        o_pix.pixel_x    = x;
        o_pix.pixel_y    = y;
        o_pix.star_pen   = star
            ? i_cfg.palette_base + {3'd0, i_lfsr[13:9]}
            : '0;

        o_next_lfsr = {i_lfsr[lsg_pkg::LFSR_W-2:0], fb};
    end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking stream testbench for the LFSR star generator with its own predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 1000;
    localparam int LONG_HOLD   = 120;

    typedef struct {
        lsg_pkg::t_op                   op;
        logic [lsg_pkg::SPEED_W-1:0]    speed;
    } t_cmd;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata   = '0;   // [1:0] operation, [4:2] speed_value, [7:5] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [31:0] m_axis_tdata;          // [0] star_write, [8:1] pixel_x, [16:9] pixel_y,
                                        // [24:17] star_pen, [31:25] zero
    logic        i_cfg_we       = 1'b0;
    logic [1:0]  i_cfg_index    = '0;
    logic [7:0]  i_cfg_data     = '0;

    lfsr_starfield_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state and register shadow.
    logic [lsg_pkg::COORD_W-1:0] pal_base;
    logic                        skip_vert;
    logic [lsg_pkg::COORD_W-1:0] win_first;
    logic [lsg_pkg::COORD_W-1:0] win_last;
    logic                        gen_on;
    logic                        phase_odd;
    logic [lsg_pkg::POS_W-1:0]   scroll_off;
    logic [lsg_pkg::LFSR_W-1:0]  start_seed;
    logic [lsg_pkg::SPEED_W-1:0] speed_reg;
    logic [lsg_pkg::LFSR_W-1:0]  star_lfsr;
    logic [lsg_pkg::POS_W-1:0]   pix_idx;

    t_cmd          pending_cmds[$];
    lsg_pkg::t_pix expected_pix[$];
    int   err_cnt      = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   hold_left    = 0;
    int   stall_mode   = 0;
    logic [5:0] mode_cnt = '0;

    task automatic flag_error(input string what);
        $display("[%0t] ERROR %s", $time, what);
        err_cnt++;
    endtask

    // Applies one accepted item to the predictor and returns the result it must cause.
    function automatic lsg_pkg::t_pix starfield_step(input lsg_pkg::t_op op,
                                                     input logic [lsg_pkg::SPEED_W-1:0] spd);
        lsg_pkg::t_pix               r;
        logic [lsg_pkg::POS_W-1:0]   pos;
        logic [lsg_pkg::COORD_W-1:0] skewed;
        logic                        fb;
        logic                        vcond;
        logic                        hit;
        r = '0;
        case (op)
            lsg_pkg::OP_PIXEL: begin
                pos = scroll_off + pix_idx;
                r.pixel_x = pos[7:0];
                r.pixel_y = pos[15:8];
                if (gen_on) begin
                    fb = ~star_lfsr[16] ^ star_lfsr[5];
                    // Bit 4 of x + 8 is unaffected by the carry out of bit 7.
                    skewed = pos[7:0] + lsg_pkg::HCOND_SKEW;
                    vcond = skip_vert ? 1'b1 : pos[8];
                    hit = (skewed[4] == vcond)
                          && (star_lfsr[7:0] == lsg_pkg::LFSR_LOW_ONES) && !fb
                          && (pos[7:0] >= win_first) && (pos[7:0] <= win_last);
                    r.star_write = hit;
                    if (hit)
                        r.star_pen = pal_base + {3'b000, star_lfsr[13:9]};
                    star_lfsr = {star_lfsr[lsg_pkg::LFSR_W-2:0], fb};
                    pix_idx = pix_idx + 1'b1;
                end
            end
            lsg_pkg::OP_FRAME_END: begin
                if (gen_on) begin
                    phase_odd = ~phase_odd;
                    if (!phase_odd) begin
                        scroll_off = scroll_off + {12'd0, speed_reg, 1'b0}
                                     - lsg_pkg::SCROLL_BIAS;
                        start_seed = lsg_pkg::LFSR_EVEN_START;
                    end else begin
                        start_seed = lsg_pkg::LFSR_ODD_START;
                    end
                end
                star_lfsr = start_seed;
                pix_idx = '0;
            end
            lsg_pkg::OP_SET_SPEED: speed_reg = spd;
            default: begin
                if (!gen_on)
                    scroll_off = '0;
                gen_on = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic push_cmd(input lsg_pkg::t_op op, input logic [lsg_pkg::SPEED_W-1:0] spd);
        t_cmd c;
        c.op = op;
        c.speed = spd;
        pending_cmds.push_back(c);
    endtask

    // Mostly whole frames of pixels closed by a frame end, mixed with speed changes
    // and stray items.
    task automatic queue_random(input int budget);
        int n;
        int len;
        int pick;
        n = 0;
        while (n < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                push_cmd(lsg_pkg::OP_SET_SPEED, 3'($urandom_range(0, 7)));
                n++;
            end else if (pick < 11) begin
                push_cmd(lsg_pkg::OP_STAR_ENABLE, 3'($urandom_range(0, 7)));
                n++;
            end else if (pick < 16) begin
                push_cmd(lsg_pkg::t_op'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
                n++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                  : $urandom_range(4, 60);
                repeat (len) push_cmd(lsg_pkg::OP_PIXEL, 3'($urandom_range(0, 7)));
                push_cmd(lsg_pkg::OP_FRAME_END, 3'($urandom_range(0, 7)));
                n += len + 1;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_pix.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input lsg_pkg::t_cfg_reg idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            lsg_pkg::CFG_PALETTE_BASE:   pal_base  = val;
            lsg_pkg::CFG_SKIP_VERTICAL:  skip_vert = val[0];
            lsg_pkg::CFG_WINDOW_FIRST_X: win_first = val;
            default:                     win_last  = val;
        endcase
    endtask

    task automatic configure(input logic [7:0] pal, input logic skip,
                             input logic [7:0] first, input logic [7:0] last);
        write_cfg(lsg_pkg::CFG_PALETTE_BASE, pal);
        write_cfg(lsg_pkg::CFG_SKIP_VERTICAL, {7'd0, skip});
        write_cfg(lsg_pkg::CFG_WINDOW_FIRST_X, first);
        write_cfg(lsg_pkg::CFG_WINDOW_LAST_X, last);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Sender: holds an offered item until it is taken, works in bursts with gaps.
    always @(posedge i_clk) begin : drv
        t_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= $urandom_range(1, 40);
            gap_left      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_pix.push_back(starfield_step(lsg_pkg::t_op'(s_axis_tdata[1:0]),
                                                      s_axis_tdata[4:2]));
            if (s_axis_tvalid && !s_axis_tready) begin
                // The offered transfer stays on the bus until it is taken.
            end else if (gap_left != 0) begin
                gap_left      <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                nxt = pending_cmds.pop_front();
                s_axis_tdata  <= {3'b000, nxt.speed, nxt.op};
                s_axis_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transfer and stalls on a changing pattern.
    always @(posedge i_clk) begin : mon
        lsg_pkg::t_pix want;
        lsg_pkg::t_pix got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            stall_mode    <= 0;
            mode_cnt      <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                got = lsg_pkg::t_pix'(m_axis_tdata[24:0]);
                if (expected_pix.size() == 0) begin
                    flag_error($sformatf("result 0x%08h with no item pending", m_axis_tdata));
                end else begin
                    want = expected_pix.pop_front();
                    if (got.star_write !== want.star_write)
                        flag_error($sformatf("result %0d star_write %b, want %b",
                                             results_seen, got.star_write, want.star_write));
                    if (got.pixel_x !== want.pixel_x)
                        flag_error($sformatf("result %0d pixel_x %0d, want %0d",
                                             results_seen, got.pixel_x, want.pixel_x));
                    if (got.pixel_y !== want.pixel_y)
                        flag_error($sformatf("result %0d pixel_y %0d, want %0d",
                                             results_seen, got.pixel_y, want.pixel_y));
                    if (got.star_pen !== want.star_pen)
                        flag_error($sformatf("result %0d star_pen %0d, want %0d",
                                             results_seen, got.star_pen, want.star_pen));
                    if (m_axis_tdata[31:25] !== 7'd0)
                        flag_error($sformatf("result %0d padding bits 0x%02h",
                                             results_seen, m_axis_tdata[31:25]));
                end
            end
            mode_cnt <= mode_cnt + 1'b1;
            if (mode_cnt == 6'd63)
                stall_mode <= $urandom_range(0, 3);
            // Long hold-offs let the block fill up and push back on the sender.
            if (m_axis_tvalid && m_axis_tready && (results_seen == 150 || results_seen == 420)) begin
                hold_left     <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= mode_cnt[1];
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        pal_base   = lsg_pkg::PALETTE_BASE_RST;
        skip_vert  = 1'b0;
        win_first  = lsg_pkg::WINDOW_FIRST_RST;
        win_last   = lsg_pkg::WINDOW_LAST_RST;
        gen_on     = 1'b0;
        phase_odd  = 1'b0;
        scroll_off = '0;
        start_seed = '0;
        speed_reg  = '0;
        star_lfsr  = '0;
        pix_idx    = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled generator first, then enable, phase flips and offset wrap.
        push_cmd(lsg_pkg::OP_PIXEL, 3'd0);
        push_cmd(lsg_pkg::OP_PIXEL, 3'd7);
        push_cmd(lsg_pkg::OP_FRAME_END, 3'd0);
        push_cmd(lsg_pkg::OP_SET_SPEED, 3'd7);
        push_cmd(lsg_pkg::OP_STAR_ENABLE, 3'd0);
        push_cmd(lsg_pkg::OP_STAR_ENABLE, 3'd5);
        push_cmd(lsg_pkg::OP_FRAME_END, 3'd0);
        push_cmd(lsg_pkg::OP_FRAME_END, 3'd0);
        // Enabling again must keep the offset that has just moved.
        push_cmd(lsg_pkg::OP_STAR_ENABLE, 3'd0);
        repeat (10) push_cmd(lsg_pkg::OP_PIXEL, 3'd2);
        push_cmd(lsg_pkg::OP_SET_SPEED, 3'd0);
        push_cmd(lsg_pkg::OP_FRAME_END, 3'd7);
        push_cmd(lsg_pkg::OP_FRAME_END, 3'd0);
        repeat (3) push_cmd(lsg_pkg::OP_PIXEL, 3'd4);
        queue_random(75);
        wait_idle();

        configure(8'd0, 1'b1, 8'd0, 8'd255);
        queue_random(100);
        wait_idle();

        // First x beyond last x leaves no place for a star.
        configure(8'd224, 1'b0, 8'd200, 8'd40);
        queue_random(100);
        wait_idle();

        configure(8'($urandom_range(0, 224)), 1'b1, 8'd16, 8'd16);
        queue_random(100);
        wait_idle();

        begin : rand_window
            logic [7:0] lo;
            lo = $urandom_range(0, 255);
            configure(8'($urandom_range(0, 224)), 1'($urandom_range(0, 1)), lo,
                      8'($urandom_range(lo, 255)));
        end
        queue_random(100);
        wait_idle();

        configure(lsg_pkg::PALETTE_BASE_RST, 1'b0, lsg_pkg::WINDOW_FIRST_RST,
                  lsg_pkg::WINDOW_LAST_RST);
        queue_random(100);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
